@@ src/mce_pkg.sv @@
// Types, microcode encodings and the Morse code table for the character encoder.
`default_nettype none
package mce_pkg;

    localparam int STEP_W = 4;
    localparam int IDX_W  = 3;

    localparam logic [7:0] ASCII_BLANK = 8'h20;
    localparam logic [7:0] ASCII_DOT   = 8'h2E;
    localparam logic [7:0] ASCII_DASH  = 8'h2D;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LGAP  = 3'd1;
    localparam logic [2:0] OP_ELEM  = 3'd2;
    localparam logic [2:0] OP_EGAP  = 3'd3;
    localparam logic [2:0] OP_WORD  = 3'd4;
    localparam logic [2:0] OP_SPACE = 3'd5;

    // jump conditions
    localparam logic [2:0] COND_NEXT      = 3'd0;
    localparam logic [2:0] COND_ALWAYS    = 3'd1;
    localparam logic [2:0] COND_NO_ITEM   = 3'd2;
    localparam logic [2:0] COND_UNSUP     = 3'd3;
    localparam logic [2:0] COND_SPACE     = 3'd4;
    localparam logic [2:0] COND_NO_LGAP   = 3'd5;
    localparam logic [2:0] COND_LAST_ELEM = 3'd6;
    localparam logic [2:0] COND_SIGNAL    = 3'd7;

    // previous-symbol flag updates
    localparam logic [1:0] PREV_KEEP = 2'd0;
    localparam logic [1:0] PREV_SET  = 2'd1;
    localparam logic [1:0] PREV_CLR  = 2'd2;

    // program addresses
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DECODE    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SPACE_CHK = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LGAP_CHK  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LGAP      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ELEM      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_EGAP      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CHAR_END  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_WORD      = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SPACE_2   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_SPACE_3   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_SPACE_END = 4'd11;

    localparam logic [2:0] REG_OUTPUT_MODE = 3'd0;
    localparam logic [2:0] REG_DOT         = 3'd1;
    localparam logic [2:0] REG_DASH        = 3'd2;
    localparam logic [2:0] REG_ELEM_GAP    = 3'd3;
    localparam logic [2:0] REG_LETTER_GAP  = 3'd4;
    localparam logic [2:0] REG_WORD_GAP    = 3'd5;

    typedef struct packed {
        logic [2:0]        op;
        logic              adv;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
        logic [1:0]        prev_op;
        logic              flush;
    } ucode_t;

    typedef struct packed {
        logic unsup;
        logic is_space;
        logic no_lgap;
        logic last_elem;
        logic notation;
    } seq_status_t;

    typedef struct packed {
        logic       output_mode;
        logic [3:0] dot_units;
        logic [3:0] dash_units;
        logic [3:0] element_gap_units;
        logic [3:0] letter_gap_units;
        logic [3:0] word_gap_units;
    } cfg_t;

    // pat[5] is the first element, 1 = dash
    typedef struct packed {
        logic       valid;
        logic [2:0] len;
        logic [5:0] pat;
    } code_t;

    function automatic code_t morse_lookup(input logic [7:0] ch);
        code_t c;
        c = '{valid: 1'b1, len: 3'd0, pat: 6'b000000};
        case (ch)
            8'h41: begin c.len = 3'd2; c.pat = 6'b010000; end // A
            8'h42: begin c.len = 3'd4; c.pat = 6'b100000; end // B
            8'h43: begin c.len = 3'd4; c.pat = 6'b101000; end // C
            8'h44: begin c.len = 3'd3; c.pat = 6'b100000; end // D
            8'h45: begin c.len = 3'd1; c.pat = 6'b000000; end // E
            8'h46: begin c.len = 3'd4; c.pat = 6'b001000; end // F
            8'h47: begin c.len = 3'd3; c.pat = 6'b110000; end // G
            8'h48: begin c.len = 3'd4; c.pat = 6'b000000; end // H
            8'h49: begin c.len = 3'd2; c.pat = 6'b000000; end // I
            8'h4A: begin c.len = 3'd4; c.pat = 6'b011100; end // J
            8'h4B: begin c.len = 3'd3; c.pat = 6'b101000; end // K
            8'h4C: begin c.len = 3'd4; c.pat = 6'b010000; end // L
            8'h4D: begin c.len = 3'd2; c.pat = 6'b110000; end // M
            8'h4E: begin c.len = 3'd2; c.pat = 6'b100000; end // N
            8'h4F: begin c.len = 3'd3; c.pat = 6'b111000; end // O
            8'h50: begin c.len = 3'd4; c.pat = 6'b011000; end // P
            8'h51: begin c.len = 3'd4; c.pat = 6'b110100; end // Q
            8'h52: begin c.len = 3'd3; c.pat = 6'b010000; end // R
            8'h53: begin c.len = 3'd3; c.pat = 6'b000000; end // S
            8'h54: begin c.len = 3'd1; c.pat = 6'b100000; end // T
            8'h55: begin c.len = 3'd3; c.pat = 6'b001000; end // U
            8'h56: begin c.len = 3'd4; c.pat = 6'b000100; end // V
            8'h57: begin c.len = 3'd3; c.pat = 6'b011000; end // W
            8'h58: begin c.len = 3'd4; c.pat = 6'b100100; end // X
            8'h59: begin c.len = 3'd4; c.pat = 6'b101100; end // Y
            8'h5A: begin c.len = 3'd4; c.pat = 6'b110000; end // Z
            8'h30: begin c.len = 3'd5; c.pat = 6'b111110; end // 0
            8'h31: begin c.len = 3'd5; c.pat = 6'b011110; end // 1
            8'h32: begin c.len = 3'd5; c.pat = 6'b001110; end // 2
            8'h33: begin c.len = 3'd5; c.pat = 6'b000110; end // 3
            8'h34: begin c.len = 3'd5; c.pat = 6'b000010; end // 4
            8'h35: begin c.len = 3'd5; c.pat = 6'b000000; end // 5
            8'h36: begin c.len = 3'd5; c.pat = 6'b100000; end // 6
            8'h37: begin c.len = 3'd5; c.pat = 6'b110000; end // 7
            8'h38: begin c.len = 3'd5; c.pat = 6'b111000; end // 8
            8'h39: begin c.len = 3'd5; c.pat = 6'b111100; end // 9
            8'h2E: begin c.len = 3'd6; c.pat = 6'b010101; end // period
            8'h3A: begin c.len = 3'd6; c.pat = 6'b111000; end // colon
            8'h27: begin c.len = 3'd6; c.pat = 6'b011110; end // apostrophe
            8'h2C: begin c.len = 3'd6; c.pat = 6'b110011; end // comma
            8'h21: begin c.len = 3'd6; c.pat = 6'b101011; end // exclamation
            8'h3F: begin c.len = 3'd6; c.pat = 6'b001100; end // question
            8'h22: begin c.len = 3'd6; c.pat = 6'b010010; end // quote
            8'h2F: begin c.len = 3'd5; c.pat = 6'b100100; end // slash
            8'h2D: begin c.len = 3'd6; c.pat = 6'b100001; end // hyphen
            8'h2B: begin c.len = 3'd5; c.pat = 6'b010100; end // plus
            8'h3D: begin c.len = 3'd5; c.pat = 6'b100010; end // equals
            8'h28: begin c.len = 3'd5; c.pat = 6'b101100; end // open paren
            8'h29: begin c.len = 3'd6; c.pat = 6'b101101; end // close paren
            8'h40: begin c.len = 3'd6; c.pat = 6'b011010; end // at sign
            8'h26: begin c.len = 3'd5; c.pat = 6'b010000; end // ampersand
            default: c.valid = 1'b0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ src/mce_ucode_rom.sv @@
// Microcode program of the encoder sequencer, one control word per step.
`default_nettype none
module mce_ucode_rom
    import mce_pkg::*;
(
    input  wire logic [STEP_W-1:0] step,
    output ucode_t                 uword
);

    always_comb begin
        case (step)
            // wait for a character beat
            STEP_IDLE:      uword = '{OP_NONE,  1'b0, COND_NO_ITEM,   STEP_IDLE,
                                      PREV_KEEP, 1'b0};
            // drop characters with no code
            STEP_DECODE:    uword = '{OP_NONE,  1'b0, COND_UNSUP,     STEP_IDLE,
                                      PREV_KEEP, 1'b0};
            STEP_SPACE_CHK: uword = '{OP_NONE,  1'b0, COND_SPACE,     STEP_WORD,
                                      PREV_KEEP, 1'b0};
            STEP_LGAP_CHK:  uword = '{OP_NONE,  1'b0, COND_NO_LGAP,   STEP_ELEM,
                                      PREV_KEEP, 1'b0};
            STEP_LGAP:      uword = '{OP_LGAP,  1'b0, COND_NEXT,      STEP_IDLE,
                                      PREV_KEEP, 1'b0};
            STEP_ELEM:      uword = '{OP_ELEM,  1'b0, COND_LAST_ELEM, STEP_CHAR_END,
                                      PREV_KEEP, 1'b0};
            STEP_EGAP:      uword = '{OP_EGAP,  1'b1, COND_ALWAYS,    STEP_ELEM,
                                      PREV_KEEP, 1'b0};
            STEP_CHAR_END:  uword = '{OP_NONE,  1'b0, COND_ALWAYS,    STEP_IDLE,
                                      PREV_SET,  1'b1};
            STEP_WORD:      uword = '{OP_WORD,  1'b0, COND_SIGNAL,    STEP_SPACE_END,
                                      PREV_KEEP, 1'b0};
            STEP_SPACE_2:   uword = '{OP_SPACE, 1'b0, COND_NEXT,      STEP_IDLE,
                                      PREV_KEEP, 1'b0};
            STEP_SPACE_3:   uword = '{OP_SPACE, 1'b0, COND_NEXT,      STEP_IDLE,
                                      PREV_KEEP, 1'b0};
            STEP_SPACE_END: uword = '{OP_NONE,  1'b0, COND_ALWAYS,    STEP_IDLE,
                                      PREV_CLR,  1'b1};
            default:        uword = '{OP_NONE,  1'b0, COND_ALWAYS,    STEP_IDLE,
                                      PREV_KEEP, 1'b0};
        endcase
    end

endmodule
`default_nettype wire

@@ src/mce_sequencer.sv @@
// Step counter with conditional jumps that walks the microcode program.
`default_nettype none
module mce_sequencer
    import mce_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        item_valid,
    input  wire logic        stall,
    input  wire seq_status_t status,
    output ucode_t           uword,
    output logic             idle
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    mce_ucode_rom u_rom (
        .step  (step_reg),
        .uword (uword)
    );

    always_comb begin
        case (uword.cond)
            COND_NEXT:      taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_NO_ITEM:   taken = !item_valid;
            COND_UNSUP:     taken = status.unsup;
            COND_SPACE:     taken = status.is_space;
            COND_NO_LGAP:   taken = status.no_lgap;
            COND_LAST_ELEM: taken = status.last_elem;
            COND_SIGNAL:    taken = !status.notation;
            default:        taken = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            step_next = step_reg;
        end else if (taken) begin
            step_next = uword.target;
        end else begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign idle = (step_reg == STEP_IDLE);

endmodule
`default_nettype wire

@@ src/mce_cfg_regs.sv @@
// APB register file for output mode and run lengths.
`default_nettype none
module mce_cfg_regs
    import mce_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{output_mode: 1'b0, dot_units: 4'd1, dash_units: 4'd3,
                         element_gap_units: 4'd1, letter_gap_units: 4'd3,
                         word_gap_units: 4'd7};
        end else if (wr_en) begin
            case (reg_idx)
                REG_OUTPUT_MODE: cfg_reg.output_mode       <= pwdata[0];
                REG_DOT:         cfg_reg.dot_units         <= pwdata[3:0];
                REG_DASH:        cfg_reg.dash_units        <= pwdata[3:0];
                REG_ELEM_GAP:    cfg_reg.element_gap_units <= pwdata[3:0];
                REG_LETTER_GAP:  cfg_reg.letter_gap_units  <= pwdata[3:0];
                REG_WORD_GAP:    cfg_reg.word_gap_units    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OUTPUT_MODE: prdata = {31'd0, cfg_reg.output_mode};
            REG_DOT:         prdata = {28'd0, cfg_reg.dot_units};
            REG_DASH:        prdata = {28'd0, cfg_reg.dash_units};
            REG_ELEM_GAP:    prdata = {28'd0, cfg_reg.element_gap_units};
            REG_LETTER_GAP:  prdata = {28'd0, cfg_reg.letter_gap_units};
            REG_WORD_GAP:    prdata = {28'd0, cfg_reg.word_gap_units};
            default:         prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

@@ src/mce_datapath.sv @@
// Character latch, code lookup, run builder and the hold/output stages.
`default_nettype none
module mce_datapath
    import mce_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire ucode_t      uword,
    input  wire logic        accept,
    input  wire logic [7:0]  in_char,
    input  wire logic        in_first,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic             m_level,
    output logic [3:0]       m_units,
    output logic [7:0]       m_char,
    output logic             m_last,
    output logic             stall,
    output seq_status_t      status
);

    logic [7:0]       char_reg;
    logic             first_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             prev_reg;
    code_t            code;
    logic [7:0]       folded;
    logic             is_dash;

    logic             cand_valid;
    logic             cand_level;
    logic [3:0]       cand_units;
    logic [7:0]       cand_char;

    logic             hold_valid_reg;
    logic             hold_level_reg;
    logic [3:0]       hold_units_reg;
    logic [7:0]       hold_char_reg;

    logic             out_valid_reg;
    logic             out_level_reg;
    logic [3:0]       out_units_reg;
    logic [7:0]       out_char_reg;
    logic             out_last_reg;

    logic             push;
    logic             notation;

    always_comb begin
        if (in_char inside {[8'h61:8'h7A]}) begin
            folded = in_char - CASE_OFFSET;
        end else begin
            folded = in_char;
        end
    end

    assign code     = morse_lookup(char_reg);
    assign notation = cfg.output_mode;
    assign is_dash  = code.pat[IDX_W'(3'd5 - idx_reg)];

    assign status.unsup     = !code.valid && (char_reg != ASCII_BLANK);
    assign status.is_space  = (char_reg == ASCII_BLANK);
    assign status.no_lgap   = !prev_reg || first_reg;
    assign status.last_elem = (idx_reg == code.len - 3'd1);
    assign status.notation  = notation;

    // candidate result of this step; empty runs are dropped
    always_comb begin
        cand_valid = 1'b0;
        cand_level = 1'b0;
        cand_units = 4'd0;
        cand_char  = 8'd0;
        case (uword.op)
            OP_LGAP: begin
                if (notation) begin
                    cand_valid = 1'b1;
                    cand_char  = ASCII_BLANK;
                end else begin
                    cand_units = cfg.letter_gap_units;
                    cand_valid = (cfg.letter_gap_units != 4'd0);
                end
            end
            OP_ELEM: begin
                if (notation) begin
                    cand_valid = 1'b1;
                    cand_char  = is_dash ? ASCII_DASH : ASCII_DOT;
                end else begin
                    cand_level = 1'b1;
                    cand_units = is_dash ? cfg.dash_units : cfg.dot_units;
                    cand_valid = (cand_units != 4'd0);
                end
            end
            OP_EGAP: begin
                if (!notation) begin
                    cand_units = cfg.element_gap_units;
                    cand_valid = (cfg.element_gap_units != 4'd0);
                end
            end
            OP_WORD: begin
                if (notation) begin
                    cand_valid = 1'b1;
                    cand_char  = ASCII_BLANK;
                end else begin
                    cand_units = cfg.word_gap_units;
                    cand_valid = (cfg.word_gap_units != 4'd0);
                end
            end
            OP_SPACE: begin
                cand_valid = 1'b1;
                cand_char  = ASCII_BLANK;
            end
            default: ;
        endcase
    end

    // the held result moves on once the next one exists or the item ends
    assign push  = hold_valid_reg && (cand_valid || uword.flush);
    assign stall = push && out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            char_reg  <= folded;
            first_reg <= in_first;
        end
        if (!stall && cand_valid) begin
            hold_level_reg <= cand_level;
            hold_units_reg <= cand_units;
            hold_char_reg  <= cand_char;
        end
        if (!stall && push) begin
            out_level_reg <= hold_level_reg;
            out_units_reg <= hold_units_reg;
            out_char_reg  <= hold_char_reg;
            out_last_reg  <= !cand_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            prev_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                idx_reg <= '0;
            end else if (!stall && uword.adv) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (!stall) begin
                case (uword.prev_op)
                    PREV_SET: prev_reg <= 1'b1;
                    PREV_CLR: prev_reg <= 1'b0;
                    default: ;
                endcase
                if (cand_valid) begin
                    hold_valid_reg <= 1'b1;
                end else if (uword.flush) begin
                    hold_valid_reg <= 1'b0;
                end
                if (push) begin
                    out_valid_reg <= 1'b1;
                end else if (m_tready) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_level  = out_level_reg;
    assign m_units  = out_units_reg;
    assign m_char   = out_char_reg;
    assign m_last   = out_last_reg;

endmodule
`default_nettype wire

@@ src/morse_character_encoder.sv @@
// Morse encoder top level: stream ports, APB registers, sequencer and datapath.
// One character at a time, one microcode step per cycle; a stalled output holds the step.
// At most one result a cycle.
// aresetn (synchronous, active low) restores default registers and clears the symbol flag.
`default_nettype none
module morse_character_encoder
    import mce_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // characters in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [7:0] ascii_char
    input  wire logic        s_tuser,  // [0] first_of_text
    // runs or notation characters out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // [0] signal_level, [4:1] run_units, [12:5] notation_char
    output logic             m_tlast   // last_of_char
);

    cfg_t        cfg;
    ucode_t      uword;
    seq_status_t status;
    logic        stall;
    logic        idle;
    logic        accept;
    logic        out_level;
    logic [3:0]  out_units;
    logic [7:0]  out_char;

    assign s_tready = idle;
    assign accept   = idle && s_tvalid;

    mce_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mce_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .stall      (stall),
        .status     (status),
        .uword      (uword),
        .idle       (idle)
    );

    mce_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .uword    (uword),
        .accept   (accept),
        .in_char  (s_tdata),
        .in_first (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_level  (out_level),
        .m_units  (out_units),
        .m_char   (out_char),
        .m_last   (m_tlast),
        .stall    (stall),
        .status   (status)
    );

    assign m_tdata = {3'd0, out_char, out_units, out_level};

endmodule
`default_nettype wire
